// File: rtl/core/grs_pkg.sv
package grs_pkg;

   // Storage geometry.
   localparam int CHANNELS = 64;
   localparam int CH_IDX_W = $clog2(CHANNELS);

   // Field widths.
   localparam int CH_W   = 6;
   localparam int DATA_W = 16;
   localparam int GATE_W = 13;
   localparam int ADJ_W  = 24;
   localparam int DIFF_W = DATA_W + 1;
   localparam int WIDE_W = 41;

   // Fixed-point one in Q1.12 and the rounding half.
   localparam logic [GATE_W-1:0] ONE_Q12 = 13'd4096;
   localparam logic signed [WIDE_W-1:0] HALF_Q12 = 41'sd2048;

   // Operation codes.
   localparam logic OP_FORWARD  = 1'b0;
   localparam logic OP_BACKWARD = 1'b1;

   typedef logic signed [WIDE_W-1:0] wide_type;

   // Write port of both state memories.
   typedef struct packed {
      logic                fwd_we;
      logic                bwd_we;
      logic [CH_IDX_W-1:0] addr;
      logic [DATA_W-1:0]   fwd_data;
      logic [ADJ_W-1:0]    bwd_data;
   } mem_write_type;

   // Work handed from the update stage to the gradient stage.
   typedef struct packed {
      logic              op;
      logic [CH_W-1:0]   channel;
      logic              last;
      logic [DATA_W-1:0] state;
      logic [DATA_W-1:0] init_grad;
      logic [ADJ_W-1:0]  adj;
      logic [DIFF_W-1:0] diff;
      logic [GATE_W-1:0] gate_comp;
   } grad_work_type;

   // One result transaction.
   typedef struct packed {
      logic [CH_W-1:0]   channel_out;
      logic [DATA_W-1:0] state_out;
      logic [DATA_W-1:0] gate_grad;
      logic [DATA_W-1:0] value_grad;
      logic [DATA_W-1:0] init_grad;
      logic              last_out;
   } rsp_item_type;

   // Divide by 4096 with round half up (floor of x/4096 + 1/2).
   function automatic wide_type rnd_q12(input wide_type x);
      wide_type t;
      t = x + HALF_Q12;
      return t >>> 12;
   endfunction

   // Saturate to 16 bits signed.
   function automatic logic [DATA_W-1:0] sat16(input wide_type x);
      logic [DATA_W-1:0] r;
      if (x > 41'sd32767) begin
         r = 16'h7FFF;
      end else if (x < -41'sd32768) begin
         r = 16'h8000;
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

   // Saturate to 24 bits signed.
   function automatic logic [ADJ_W-1:0] sat24(input wide_type x);
      logic [ADJ_W-1:0] r;
      if (x > 41'sd8388607) begin
         r = 24'h7FFFFF;
      end else if (x < -41'sd8388608) begin
         r = 24'h800000;
      end else begin
         r = x[ADJ_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/core/grs_req_if.sv
interface grs_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  operation;
   logic [grs_pkg::CH_W-1:0]              channel;
   logic [grs_pkg::GATE_W-1:0]            gate;
   logic signed [grs_pkg::DATA_W-1:0]     value;
   logic signed [grs_pkg::DATA_W-1:0]     prev_state;
   logic signed [grs_pkg::DATA_W-1:0]     upstream_grad;
   logic signed [grs_pkg::DATA_W-1:0]     seed;
   logic                                  first;
   logic                                  last;

   modport source (
      output valid, operation, channel, gate, value, prev_state, upstream_grad, seed,
             first, last,
      input  ready
   );

   modport sink (
      input  valid, operation, channel, gate, value, prev_state, upstream_grad, seed,
             first, last,
      output ready
   );
endinterface

// File: rtl/core/grs_rsp_if.sv
interface grs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [grs_pkg::CH_W-1:0]          channel_out;
   logic signed [grs_pkg::DATA_W-1:0] state_out;
   logic signed [grs_pkg::DATA_W-1:0] gate_grad;
   logic signed [grs_pkg::DATA_W-1:0] value_grad;
   logic signed [grs_pkg::DATA_W-1:0] init_grad;
   logic                              last_out;

   modport source (
      output valid, channel_out, state_out, gate_grad, value_grad, init_grad, last_out,
      input  ready
   );

   modport sink (
      input  valid, channel_out, state_out, gate_grad, value_grad, init_grad, last_out,
      output ready
   );
endinterface

// File: rtl/core/grs_ram.sv
module grs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; returns the old contents on a same-cycle write.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/grs_update.sv
module grs_update (
   input  logic                              clock,
   input  logic                              reset,
   grs_req_if.sink                           req_ch,
   input  logic [grs_pkg::DATA_W-1:0]        fwd_rd_data,
   input  logic [grs_pkg::ADJ_W-1:0]         bwd_rd_data,
   output grs_pkg::mem_write_type            mem_wr,
   output logic                              work_valid,
   output grs_pkg::grad_work_type            work,
   input  logic                              work_ready
);

   // Latched transaction, waiting for its memory read data.
   logic                              s1_vld_ff, s1_vld_in;
   logic                              s1_op_ff;
   logic [grs_pkg::CH_W-1:0]          s1_ch_ff;
   logic [grs_pkg::GATE_W-1:0]        s1_gate_ff;
   logic signed [grs_pkg::DATA_W-1:0] s1_value_ff;
   logic signed [grs_pkg::DATA_W-1:0] s1_prev_ff;
   logic signed [grs_pkg::DATA_W-1:0] s1_up_ff;
   logic signed [grs_pkg::DATA_W-1:0] s1_seed_ff;
   logic                              s1_first_ff;
   logic                              s1_last_ff;

   // Most recent memory write, used to bypass a read that missed it.
   logic                              byp_vld_ff;
   logic                              byp_op_ff;
   logic [grs_pkg::CH_IDX_W-1:0]      byp_idx_ff;
   logic [grs_pkg::ADJ_W-1:0]         byp_data_ff;

   logic                              accept;
   logic                              advance;
   logic [grs_pkg::CH_IDX_W-1:0]      idx;
   logic                              hit;
   logic [grs_pkg::GATE_W-1:0]        gate_c;
   logic [grs_pkg::GATE_W-1:0]        gate_comp;
   logic signed [grs_pkg::DATA_W-1:0] fwd_src;
   logic signed [29:0]                fwd_p0;
   logic signed [29:0]                fwd_p1;
   logic [grs_pkg::DATA_W-1:0]        new_state;
   logic signed [grs_pkg::ADJ_W-1:0]  adj_src;
   logic signed [grs_pkg::ADJ_W-1:0]  adj_cur;
   logic signed [37:0]                adj_p;
   logic [grs_pkg::ADJ_W-1:0]         adj_new;
   logic [grs_pkg::DIFF_W-1:0]        diff;

   assign req_ch.ready = !s1_vld_ff || work_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign advance      = s1_vld_ff && work_ready;

   // Stage valid: a new transaction replaces the one leaving.
   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (advance) begin
         s1_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_ch.operation;
         s1_ch_ff    <= req_ch.channel;
         s1_gate_ff  <= req_ch.gate;
         s1_value_ff <= req_ch.value;
         s1_prev_ff  <= req_ch.prev_state;
         s1_up_ff    <= req_ch.upstream_grad;
         s1_seed_ff  <= req_ch.seed;
         s1_first_ff <= req_ch.first;
         s1_last_ff  <= req_ch.last;
      end
   end

   // Operand selection: seed, bypassed write, or memory contents.
   assign idx = s1_ch_ff[grs_pkg::CH_IDX_W-1:0];
   assign hit = byp_vld_ff && (byp_op_ff == s1_op_ff) && (byp_idx_ff == idx);

   assign gate_c    = (s1_gate_ff > grs_pkg::ONE_Q12) ? grs_pkg::ONE_Q12 : s1_gate_ff;
   assign gate_comp = grs_pkg::ONE_Q12 - gate_c;

   always_comb begin
      if (s1_first_ff) begin
         fwd_src = s1_seed_ff;
         adj_src = grs_pkg::ADJ_W'(s1_seed_ff);
      end else if (hit) begin
         fwd_src = $signed(byp_data_ff[grs_pkg::DATA_W-1:0]);
         adj_src = $signed(byp_data_ff);
      end else begin
         fwd_src = $signed(fwd_rd_data);
         adj_src = $signed(bwd_rd_data);
      end
   end

   // Forward step: g*s + (1-g)*v, rounded and saturated.
   assign fwd_p0    = $signed({1'b0, gate_c}) * fwd_src;
   assign fwd_p1    = $signed({1'b0, gate_comp}) * s1_value_ff;
   assign new_state = grs_pkg::sat16(grs_pkg::rnd_q12(
                         grs_pkg::wide_type'(fwd_p0) + grs_pkg::wide_type'(fwd_p1)));

   // Backward step: accumulate the upstream gradient, then scale by the gate.
   assign adj_cur = $signed(grs_pkg::sat24(grs_pkg::wide_type'(adj_src)
                                         + grs_pkg::wide_type'(s1_up_ff)));
   assign adj_p   = adj_cur * $signed({1'b0, gate_c});
   assign adj_new = grs_pkg::sat24(grs_pkg::rnd_q12(grs_pkg::wide_type'(adj_p)));
   assign diff    = $signed({s1_prev_ff[grs_pkg::DATA_W-1], s1_prev_ff})
                  - $signed({s1_value_ff[grs_pkg::DATA_W-1], s1_value_ff});

   // Write back to the memory of this operation as the transaction moves on.
   assign mem_wr.fwd_we   = advance && (s1_op_ff == grs_pkg::OP_FORWARD);
   assign mem_wr.bwd_we   = advance && (s1_op_ff == grs_pkg::OP_BACKWARD);
   assign mem_wr.addr     = idx;
   assign mem_wr.fwd_data = new_state;
   assign mem_wr.bwd_data = adj_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_vld_ff <= 1'b0;
      end else if (advance) begin
         byp_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byp_op_ff   <= s1_op_ff;
         byp_idx_ff  <= idx;
         byp_data_ff <= (s1_op_ff == grs_pkg::OP_FORWARD) ?
                        grs_pkg::ADJ_W'($signed(new_state)) : adj_new;
      end
   end

   // Hand-off to the gradient stage.
   always_comb begin
      work.op        = s1_op_ff;
      work.channel   = s1_ch_ff;
      work.last      = s1_last_ff;
      work.adj       = adj_cur;
      work.diff      = diff;
      work.gate_comp = gate_comp;
      if (s1_op_ff == grs_pkg::OP_FORWARD) begin
         work.state     = new_state;
         work.init_grad = '0;
      end else begin
         work.state     = '0;
         work.init_grad = s1_last_ff ?
                          grs_pkg::sat16(grs_pkg::wide_type'($signed(adj_new))) : '0;
      end
   end

   assign work_valid = s1_vld_ff;

endmodule

// File: rtl/core/grs_grad.sv
module grs_grad (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   work_valid,
   input  grs_pkg::grad_work_type work,
   output logic                   work_ready,
   grs_rsp_if.source              rsp_ch
);

   logic                   s2_vld_ff, s2_vld_in;
   grs_pkg::grad_work_type s2_ff;
   logic                   out_vld_ff, out_vld_in;
   grs_pkg::rsp_item_type  out_ff, out_in;
   logic                   out_ready;
   logic                   s2_adv;
   logic signed [40:0]     gg_p;
   logic signed [37:0]     gv_p;

   assign out_ready  = !out_vld_ff || rsp_ch.ready;
   assign work_ready = !s2_vld_ff || out_ready;
   assign s2_adv     = s2_vld_ff && out_ready;

   // Product stage register.
   always_comb begin
      s2_vld_in = s2_vld_ff;
      if (work_valid && work_ready) begin
         s2_vld_in = 1'b1;
      end else if (s2_adv) begin
         s2_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (work_valid && work_ready) begin
         s2_ff <= work;
      end
   end

   // Gradients of gate and value from the accumulated adjoint.
   assign gg_p = $signed(s2_ff.adj) * $signed(s2_ff.diff);
   assign gv_p = $signed(s2_ff.adj) * $signed({1'b0, s2_ff.gate_comp});

   always_comb begin
      out_in.channel_out = s2_ff.channel;
      out_in.state_out   = s2_ff.state;
      out_in.init_grad   = s2_ff.init_grad;
      out_in.last_out    = s2_ff.last;
      if (s2_ff.op == grs_pkg::OP_BACKWARD) begin
         out_in.gate_grad  = grs_pkg::sat16(grs_pkg::rnd_q12(gg_p));
         out_in.value_grad = grs_pkg::sat16(grs_pkg::rnd_q12(grs_pkg::wide_type'(gv_p)));
      end else begin
         out_in.gate_grad  = '0;
         out_in.value_grad = '0;
      end
   end

   // Output register holding the result until the receiver takes it.
   always_comb begin
      out_vld_in = out_vld_ff;
      if (s2_adv) begin
         out_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid       = out_vld_ff;
   assign rsp_ch.channel_out = out_ff.channel_out;
   assign rsp_ch.state_out   = $signed(out_ff.state_out);
   assign rsp_ch.gate_grad   = $signed(out_ff.gate_grad);
   assign rsp_ch.value_grad  = $signed(out_ff.value_grad);
   assign rsp_ch.init_grad   = $signed(out_ff.init_grad);
   assign rsp_ch.last_out    = out_ff.last_out;

endmodule

// File: rtl/core/gated_recurrence_scan.sv
// Gated linear recurrence with its gradient, one state entry per channel.
// Request channel (req_ch): a forward transaction updates the channel's state
// to g*s + (1-g)*v and returns it in state_out; a backward transaction, fed in
// reverse time order, adds upstream_grad to the channel's adjoint and returns
// the gate and value gradients, plus the initial-state gradient when last.
// The first flag loads the seed in place of the stored state or adjoint.
// Response channel (rsp_ch): exactly one transaction per request, in order.
// Response valid rises once the transaction is in the output register.
// Throughput is one transaction per cycle without back-pressure, also for the
// same channel back to back: the state memories are read at acceptance and
// written on advance; the last write is bypassed to a read that missed it.
// The loop that sets the rate is the read-modify-write of the state memories.
// Reset clears the pipeline valid bits only; stored state is undefined until a
// first transaction of that channel writes it, and no clearing pass is run.
// When the receiver stalls, the output register holds the response and the
// pipeline keeps filling; ready drops once all three stages are occupied.
module gated_recurrence_scan (
   input  logic      clock,
   input  logic      reset,
   grs_req_if.sink   req_ch,
   grs_rsp_if.source rsp_ch
);

   logic                                  rd_en;
   logic [grs_pkg::DATA_W-1:0]            fwd_rd_data;
   logic [grs_pkg::ADJ_W-1:0]             bwd_rd_data;
   grs_pkg::mem_write_type                mem_wr;
   logic                                  work_valid;
   logic                                  work_ready;
   grs_pkg::grad_work_type                work;

   // Both memories are read as each transaction is accepted.
   assign rd_en = req_ch.valid && req_ch.ready;

   grs_ram #(
      .WIDTH (grs_pkg::DATA_W),
      .DEPTH (grs_pkg::CHANNELS)
   ) u_fwd_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (req_ch.channel[grs_pkg::CH_IDX_W-1:0]),
      .rd_data (fwd_rd_data),
      .wr_en   (mem_wr.fwd_we),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.fwd_data)
   );

   grs_ram #(
      .WIDTH (grs_pkg::ADJ_W),
      .DEPTH (grs_pkg::CHANNELS)
   ) u_adj_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (req_ch.channel[grs_pkg::CH_IDX_W-1:0]),
      .rd_data (bwd_rd_data),
      .wr_en   (mem_wr.bwd_we),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.bwd_data)
   );

   grs_update u_update (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .fwd_rd_data (fwd_rd_data),
      .bwd_rd_data (bwd_rd_data),
      .mem_wr      (mem_wr),
      .work_valid  (work_valid),
      .work        (work),
      .work_ready  (work_ready)
   );

   grs_grad u_grad (
      .clock      (clock),
      .reset      (reset),
      .work_valid (work_valid),
      .work       (work),
      .work_ready (work_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule
